>>> hdl/tird_pkg.sv
// shared types, codes and constants of the tape image record deframer
`default_nettype none
package tird_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 24;
    localparam int HDR_W    = 32;
    localparam int KIND_W   = 2;
    localparam int CAUSE_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

    // error causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TOO_LONG = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_BAD_FLAG = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_TRAILER  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_META_FLAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EOM_LEN   = 2'd2;

    localparam logic [LEN_W-1:0]  MAX_LEN_RST   = 24'hFFFFFF;
    localparam logic [BYTE_W-1:0] META_FLAG_RST = 8'hFF;
    localparam logic [LEN_W-1:0]  EOM_LEN_RST   = 24'hFFFFFF;

    typedef struct packed {
        logic [LEN_W-1:0]  max_len;
        logic [BYTE_W-1:0] meta_flag;
        logic [LEN_W-1:0]  eom_len;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   length;
        logic [CAUSE_W-1:0] cause;
    } result_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage
`default_nettype wire

>>> hdl/tird_if.sv
// byte and result channel interfaces of the deframer
`default_nettype none
interface tird_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tird_pkg::BYTE_W-1:0] tape_byte;

    modport source (output valid, output tape_byte, input ready);
    modport sink   (input valid, input tape_byte, output ready);
endinterface

interface tird_result_if;
    logic                          valid;
    logic                          ready;
    logic [tird_pkg::KIND_W-1:0]   result_kind;
    logic [tird_pkg::BYTE_W-1:0]   data_byte;
    logic [tird_pkg::LEN_W-1:0]    record_length;
    logic [tird_pkg::CAUSE_W-1:0]  error_cause;

    modport source (output valid, output result_kind, output data_byte,
                    output record_length, output error_cause, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input record_length, input error_cause, output ready);
endinterface
`default_nettype wire

>>> hdl/tird_front.sv
// front: accepts tape bytes, tracks header, data and trailer, emits results
`default_nettype none
module tird_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tird_pkg::cfg_t    cfg,
    input  wire logic              q_full,
    tird_byte_if.sink              tape,
    output logic                   push,
    output tird_pkg::result_t      res
);
    import tird_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_DATA    = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    localparam logic [2:0] TCNT_LAST  = 3'd3;
    localparam logic [2:0] TCNT_EXTRA = 3'd4;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [HDR_W-1:0] hdr_reg, hdr_next;
    logic [HDR_W-1:0] win_reg, win_next;
    logic [2:0]       tcnt_reg, tcnt_next;

    logic             accept;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] cnt_inc;
    logic [HDR_W-1:0] full_hdr;
    logic [LEN_W-1:0] full_len;
    logic [BYTE_W-1:0] full_flag;
    logic [HDR_W-1:0] cand;
    logic [HDR_W-1:0] shifted;

    assign tape.ready = !q_full;
    assign accept     = tape.valid && tape.ready;
    assign b          = tape.tape_byte;
    assign hdr_len    = hdr_reg[LEN_W-1:0];
    assign cnt_inc    = cnt_reg + 1'b1;
    assign full_hdr   = {b, hdr_reg[LEN_W-1:0]};
    assign full_len   = full_hdr[LEN_W-1:0];
    assign full_flag  = full_hdr[HDR_W-1:LEN_W];
    assign cand       = {b, win_reg[LEN_W-1:0]};
    assign shifted    = {b, win_reg[HDR_W-1:BYTE_W]};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        win_next   = win_reg;
        tcnt_next  = tcnt_reg;
        push       = 1'b0;
        res        = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_DATA:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= hdr_len)
                    begin
                        phase_next = PH_TRAILER;
                        tcnt_next  = '0;
                        win_next   = '0;
                    end
                    push     = 1'b1;
                    res.kind = KIND_DATA;
                    res.data = b;
                end
                PH_TRAILER:
                begin
                    if (tcnt_reg == TCNT_EXTRA)
                    begin
                        // odd length: pad byte slipped in, retry one byte later
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                        tcnt_next  = '0;
                        win_next   = '0;
                        push       = 1'b1;
                        if (shifted == hdr_reg)
                        begin
                            res.kind   = KIND_END;
                            res.length = hdr_len;
                        end
                        else
                        begin
                            res.kind  = KIND_ERR;
                            res.cause = CAUSE_TRAILER;
                        end
                    end
                    else if (tcnt_reg == TCNT_LAST)
                    begin
                        if (cand == hdr_reg)
                        begin
                            phase_next = PH_HEADER;
                            cnt_next   = '0;
                            tcnt_next  = '0;
                            win_next   = '0;
                            push       = 1'b1;
                            res.kind   = KIND_END;
                            res.length = hdr_len;
                        end
                        else if (hdr_reg[0])
                        begin
                            tcnt_next = TCNT_EXTRA;
                            win_next  = cand;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                            cnt_next   = '0;
                            tcnt_next  = '0;
                            win_next   = '0;
                            push       = 1'b1;
                            res.kind   = KIND_ERR;
                            res.cause  = CAUSE_TRAILER;
                        end
                    end
                    else
                    begin
                        win_next[tcnt_reg[1:0]*BYTE_W +: BYTE_W] = b;
                        tcnt_next = tcnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                    if (cnt_reg[1:0] == 2'd0)
                        hdr_next = {{(HDR_W-BYTE_W){1'b0}}, b};
                    else
                        hdr_next[cnt_reg[1:0]*BYTE_W +: BYTE_W] = b;
                    cnt_next = cnt_inc;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        cnt_next  = '0;
                        tcnt_next = '0;
                        win_next  = '0;
                        if (full_len == '0 && full_flag == '0)
                        begin
                            push     = 1'b1;
                            res.kind = KIND_MARK;
                        end
                        else if (full_flag == cfg.meta_flag && full_len == cfg.eom_len)
                        begin
                            push     = 1'b1;
                            res.kind = KIND_MARK;
                        end
                        else if (full_len > cfg.max_len)
                        begin
                            push      = 1'b1;
                            res.kind  = KIND_ERR;
                            res.cause = CAUSE_TOO_LONG;
                        end
                        else if (full_flag != '0)
                        begin
                            push      = 1'b1;
                            res.kind  = KIND_ERR;
                            res.cause = CAUSE_BAD_FLAG;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            hdr_reg   <= '0;
            win_reg   <= '0;
            tcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            hdr_reg   <= hdr_next;
            win_reg   <= win_next;
            tcnt_reg  <= tcnt_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tird_queue.sv
// short result queue between front and back
`default_nettype none
module tird_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire tird_pkg::result_t   push_data,
    input  wire logic                pop,
    output tird_pkg::result_t        head,
    output tird_pkg::q_status_t      status
);
    import tird_pkg::*;

    result_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head             = mem_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tird_back.sv
// back: moves queued results into the output register
`default_nettype none
module tird_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tird_pkg::result_t   head,
    input  wire tird_pkg::q_status_t status,
    output logic                     pop,
    tird_result_if.source            result
);
    import tird_pkg::*;

    logic    out_valid_reg;
    result_t out_data_reg;

    assign pop = status.not_empty && (!out_valid_reg || result.ready);

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_data_reg.kind;
    assign result.data_byte     = out_data_reg.data;
    assign result.record_length = out_data_reg.length;
    assign result.error_cause   = out_data_reg.cause;

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

endmodule
`default_nettype wire

>>> hdl/tape_image_record_deframer.sv
// top level: tape image record deframer with front, result queue and back
// a result passes a queue entry, then the back's output register; throughput: one
// tape byte per cycle unless stalled, set by the front's per-byte compare and count
// the four-entry result queue lets the front run on while the output stalls
// reset: asynchronous active low, clears control state and loads register defaults
// no clearing pass: the block takes bytes as soon as reset is released
`default_nettype none
module tape_image_record_deframer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tird_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tird_pkg::CFG_DATA_W-1:0] cfg_data,
    tird_byte_if.sink                          tape,
    tird_result_if.source                      result
);
    import tird_pkg::*;

    // configuration registers, written only while idle by the user; not enforced here
    cfg_t      cfg_reg;

    // front to queue
    logic      q_push;
    result_t   q_push_data;

    // queue to back
    logic      q_pop;
    result_t   q_head;
    q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_len   <= MAX_LEN_RST;
            cfg_reg.meta_flag <= META_FLAG_RST;
            cfg_reg.eom_len   <= EOM_LEN_RST;
        end
        else if (cfg_we)
        begin
            // writes beyond the register list fall through and are dropped
            case (cfg_index)
                REG_MAX_LEN:   cfg_reg.max_len   <= cfg_data[LEN_W-1:0];
                REG_META_FLAG: cfg_reg.meta_flag <= cfg_data[BYTE_W-1:0];
                REG_EOM_LEN:   cfg_reg.eom_len   <= cfg_data[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // front: header collection, data pass-through, trailer check
    tird_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_full (q_status.full),
        .tape   (tape),
        .push   (q_push),
        .res    (q_push_data)
    );

    // short queue so front and back stall independently
    tird_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: output register toward the result channel
    tird_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .status (q_status),
        .pop    (q_pop),
        .result (result)
    );

    // input beat is taken whenever the queue has room
    a_ready_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
        tape.ready == !q_status.full)
        else $error("tape ready does not follow queue space");

    // the front never pushes into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("result pushed into full queue");

    // a data beat carries no length and no cause
    a_data_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.result_kind == KIND_DATA) |->
        (result.record_length == '0 && result.error_cause == CAUSE_NONE))
        else $error("data beat with stray length or cause");

    // an error beat always names a cause, and only an error beat does
    a_cause_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        ((result.result_kind == KIND_ERR) == (result.error_cause != CAUSE_NONE)))
        else $error("error cause inconsistent with result kind");

endmodule
`default_nettype wire

>>> verif/tird_checker.sv
// deframer checker: watches config, byte and result channels, predicts and compares
`timescale 1ns / 1ps
module tird_checker
    import tird_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    tird_byte_if                       tape,
    tird_result_if                     result,
    output int                         errors,
    output int                         pending
);

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        IN_DATA,
        IN_TRAILER
    } parse_phase_e;

    // register copies
    logic [LEN_W-1:0]  limit_len;
    logic [BYTE_W-1:0] meta_flag;
    logic [LEN_W-1:0]  eom_len;

    // parser copy
    parse_phase_e      cur_phase;
    logic [HDR_W-1:0]  hdr_word;
    logic [LEN_W-1:0]  count_in_phase;
    logic [39:0]       trailer_bytes;
    logic [2:0]        trailer_fill;

    result_t           expected_results[$];
    result_t           got;
    result_t           want;
    int                fail_count;

    task automatic back_to_header();
        cur_phase      = AWAIT_HEADER;
        count_in_phase = '0;
        trailer_bytes  = '0;
        trailer_fill   = '0;
    endtask

    task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                                input logic [LEN_W-1:0] length,
                                input logic [CAUSE_W-1:0] cause);
        expected_results.push_back({kind, data, length, cause});
    endtask

    // one tape byte through the parser copy
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] flag;
        logic [HDR_W-1:0]  shifted;
        len = hdr_word[LEN_W-1:0];
        case (cur_phase)
            IN_DATA:
            begin
                count_in_phase = count_in_phase + 1'b1;
                if (count_in_phase >= len)
                begin
                    cur_phase     = IN_TRAILER;
                    trailer_bytes = '0;
                    trailer_fill  = '0;
                end
                queue_result(KIND_DATA, b, '0, CAUSE_NONE);
            end
            IN_TRAILER:
            begin
                if (trailer_fill < 3'd4)
                begin
                    trailer_bytes[trailer_fill*8 +: 8] = b;
                    trailer_fill = trailer_fill + 1'b1;
                    if (trailer_fill == 3'd4)
                    begin
                        if (trailer_bytes[31:0] == hdr_word)
                        begin
                            back_to_header();
                            queue_result(KIND_END, '0, len, CAUSE_NONE);
                        end
                        else if (!len[0])
                        begin
                            back_to_header();
                            queue_result(KIND_ERR, '0, '0, CAUSE_TRAILER);
                        end
                    end
                end
                else
                begin
                    // odd length: drop the pad byte and look again
                    trailer_bytes[39:32] = b;
                    shifted = trailer_bytes[39:8];
                    back_to_header();
                    if (shifted == hdr_word)
                        queue_result(KIND_END, '0, len, CAUSE_NONE);
                    else
                        queue_result(KIND_ERR, '0, '0, CAUSE_TRAILER);
                end
            end
            default:
            begin
                cur_phase = AWAIT_HEADER;
                if (count_in_phase > 3)
                    count_in_phase = '0;
                if (count_in_phase == 0)
                    hdr_word = '0;
                hdr_word[count_in_phase[1:0]*8 +: 8] = b;
                count_in_phase = count_in_phase + 1'b1;
                if (count_in_phase == 4)
                begin
                    len  = hdr_word[LEN_W-1:0];
                    flag = hdr_word[HDR_W-1:LEN_W];
                    back_to_header();
                    if (len == 0 && flag == 0)
                        queue_result(KIND_MARK, '0, '0, CAUSE_NONE);
                    else if (flag == meta_flag && len == eom_len)
                        queue_result(KIND_MARK, '0, '0, CAUSE_NONE);
                    else if (len > limit_len)
                        queue_result(KIND_ERR, '0, '0, CAUSE_TOO_LONG);
                    else if (flag != 0)
                        queue_result(KIND_ERR, '0, '0, CAUSE_BAD_FLAG);
                    else
                    begin
                        cur_phase      = IN_DATA;
                        count_in_phase = '0;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_len  = MAX_LEN_RST;
            meta_flag  = META_FLAG_RST;
            eom_len    = EOM_LEN_RST;
            hdr_word   = '0;
            back_to_header();
            expected_results.delete();
            fail_count = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_LEN:   limit_len = cfg_data[LEN_W-1:0];
                    REG_META_FLAG: meta_flag = cfg_data[BYTE_W-1:0];
                    REG_EOM_LEN:   eom_len   = cfg_data[LEN_W-1:0];
                    default:       ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got = {result.result_kind, result.data_byte, result.record_length,
                       result.error_cause};
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result kind %0d data %02h length %06h cause %0d",
                             $time, got.kind, got.data, got.length, got.cause);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== got)
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch: expected kind %0d data %02h ",
                                  "length %06h cause %0d, got kind %0d data %02h ",
                                  "length %06h cause %0d"},
                                 $time, want.kind, want.data, want.length, want.cause,
                                 got.kind, got.data, got.length, got.cause);
                    end
                end
            end
            if (tape.valid && tape.ready)
                deframe_byte(tape.tape_byte);
            pending <= expected_results.size();
            errors  <= fail_count;
        end
    end

endmodule

>>> verif/testbench.sv
// testbench top: tape image stimulus, result back-pressure and the verdict
`timescale 1ns / 1ps
module testbench;
    import tird_pkg::*;

    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_BYTES = 320;
    localparam int LONG_HOLD   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;

    tird_byte_if   tape_ch ();
    tird_result_if result_ch ();

    tape_image_record_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tape      (tape_ch),
        .result    (result_ch)
    );

    tird_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tape      (tape_ch),
        .result    (result_ch),
        .errors    (errors),
        .pending   (pending)
    );

    // settings the stimulus believes are loaded, used to keep records in step
    logic [LEN_W-1:0]  tb_max;
    logic [BYTE_W-1:0] tb_meta;
    logic [LEN_W-1:0]  tb_eom;

    int bytes_sent;
    bit steady;          // record sent without any gaps between beats
    bit random_started;  // lets the receiver start its long hold-off

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // one tape byte: optional idle gap, then hold the beat until taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        int r;
        gap = 0;
        if (!steady)
        begin
            r = $urandom_range(0, 99);
            if (r >= 96)
                gap = $urandom_range(8, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            tape_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tape_ch.valid     <= 1'b1;
        tape_ch.tape_byte <= b;
        @(posedge clk);
        while (!tape_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // header is little-endian length then flag
    task automatic send_header(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] flag);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(len[23:16]);
        send_byte(flag);
    endtask

    // full record: header, data, trailer; padded adds the tolerated pad byte on
    // odd lengths, broken corrupts one trailer byte
    task automatic send_record(input logic [LEN_W-1:0] len, input bit padded, input bit broken);
        logic [HDR_W-1:0]  hdr;
        logic [HDR_W-1:0]  trl;
        logic [BYTE_W-1:0] pad;
        int                k;
        bit                header_only;
        // headers the block turns into a mark or an error carry no body
        header_only = (len == 0) || (len > tb_max) || (tb_meta == 0 && len == tb_eom);
        send_header(len, 8'h00);
        if (!header_only)
        begin
            repeat (len) send_byte(8'($urandom_range(0, 255)));
            hdr = {8'h00, len};
            trl = hdr;
            if (broken)
            begin
                k = $urandom_range(0, 3);
                trl[k*8 +: 8] = trl[k*8 +: 8] ^ 8'($urandom_range(1, 255));
            end
            if (padded && len[0] && !broken)
            begin
                // pad differs from the first header byte so the first window misses
                pad = hdr[7:0] ^ 8'($urandom_range(1, 255));
                send_byte(pad);
            end
            for (int i = 0; i < 4; i++)
                send_byte(trl[i*8 +: 8]);
            // odd length mismatch makes the block pull one more byte
            if (broken && len[0])
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_record();
        int               pick;
        int               cap;
        int               lo;
        logic [LEN_W-1:0] len;
        pick   = $urandom_range(0, 99);
        steady = ($urandom_range(0, 3) == 0);
        // mostly short records, a few longer ones
        cap = ($urandom_range(0, 9) == 0) ? 64 : 12;
        if (tb_max < cap)
            cap = int'(tb_max);
        if (pick < 50)
        begin
            if (cap == 0)
                send_header('0, 8'h00);
            else
                send_record(LEN_W'($urandom_range(1, cap)), 1'($urandom_range(0, 1)), 1'b0);
        end
        else if (pick < 58)
            send_header('0, 8'h00);
        else if (pick < 64)
            send_header(tb_eom, tb_meta);
        else if (pick < 70 && tb_max != 24'hFFFFFF)
        begin
            lo = int'(tb_max) + 1;
            send_header(LEN_W'($urandom_range(lo, 24'hFFFFFF)), 8'($urandom_range(0, 255)));
        end
        else if (pick < 78)
        begin
            // nonzero flag, length anywhere
            len = ($urandom_range(0, 1) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 64));
            send_header(len, 8'($urandom_range(1, 255)));
        end
        else if (pick < 88)
        begin
            if (cap == 0)
                send_header('0, 8'h00);
            else
                send_record(LEN_W'($urandom_range(1, cap)), 1'b0, 1'b1);
        end
        else
        begin
            // raw noise, may knock the stream out of record alignment
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // wait until the block is idle before touching registers
    task automatic settle();
        tape_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // header and trailer bytes cause nothing, give the pipe its latency
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic [LEN_W-1:0] max_len, input logic [BYTE_W-1:0] meta,
                                  input logic [LEN_W-1:0] eom, input bit touch_unused);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_LEN;
        cfg_data  <= max_len;
        @(posedge clk);
        // upper bits are junk, only the low byte counts
        cfg_index <= REG_META_FLAG;
        cfg_data  <= {16'($urandom), meta};
        @(posedge clk);
        cfg_index <= REG_EOM_LEN;
        cfg_data  <= eom;
        @(posedge clk);
        if (touch_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_we  <= 1'b0;
        tb_max  = max_len;
        tb_meta = meta;
        tb_eom  = eom;
    endtask

    // receiver: bursts of ready and stalls, plus one long hold-off
    initial
    begin
        int  r;
        bit  held_long;
        held_long = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (random_started && !held_long)
            begin
                // queue fills and the byte side must stall
                held_long = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                begin
                    result_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
                else if (r < 9)
                begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int phase_end;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_MAX_LEN;
        cfg_data          <= '0;
        tape_ch.valid     <= 1'b0;
        tape_ch.tape_byte <= '0;
        tb_max            = MAX_LEN_RST;
        tb_meta           = META_FLAG_RST;
        tb_eom            = EOM_LEN_RST;
        bytes_sent        = 0;
        steady            = 1'b0;
        random_started    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with reset settings
        send_header('0, 8'h00);              // tapemark
        send_header(EOM_LEN_RST, META_FLAG_RST); // end of medium
        steady = 1'b1;
        send_record(24'd2, 1'b0, 1'b0);      // even length, exact trailer
        send_record(24'd1, 1'b1, 1'b0);      // odd length with pad byte
        steady = 1'b0;
        send_header(24'd3, 8'h80);           // illegal flag

        random_started = 1'b1;
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1: write_settings(24'd40, 8'($urandom_range(0, 255)),
                                      LEN_W'($urandom_range(0, 40)), 1'b0);
                    2: write_settings(24'd0, 8'h00, 24'h000000, 1'b0);
                    3: write_settings(24'hFFFFFF, 8'hFF, 24'hFFFFFF, 1'b1);
                    default: write_settings(LEN_W'($urandom_range(1, 200)),
                                            8'($urandom_range(1, 254)),
                                            LEN_W'($urandom_range(0, 200)), 1'b0);
                endcase
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_record();
        end

        // drain, then leave room for any stray beat
        settle();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
